FILE: rtl/core/sparse_row_matvec_with_dots_top_macros.svh
// Assertion macros shared by the sparse row matvec RTL
`ifndef SPARSE_ROW_MATVEC_WITH_DOTS_TOP_MACROS_SVH
`define SPARSE_ROW_MATVEC_WITH_DOTS_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// checked only while out of reset
`define SRMV_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("srmv assertion failed");
// checked on every edge, reset included
`define SRMV_ASSERT_ALW(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("srmv assertion failed");
`else
`define SRMV_ASSERT(name, prop)
`define SRMV_ASSERT_ALW(name, prop)
`endif

`endif

FILE: rtl/core/srmv_pkg.sv
// Package: widths, codes and sequencer states of the sparse row matvec block
package srmv_pkg;

  // vector store geometry
  localparam int VECTOR_DEPTH = 1024;
  localparam int VEC_AW       = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

  // field widths
  localparam int IDX_W = 10;
  localparam int VAL_W = 32;
  localparam int ACC_W = 64;
  localparam int RR_W  = 63;

  // item kinds
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_NZ   = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SQR,
    ST_PLO,
    ST_PHI,
    ST_CMB,
    ST_PAP
  } srmv_state_e;

endpackage

FILE: rtl/core/srmv_if.sv
// Valid/ready channel interfaces for input and result items
interface srmv_in_if import srmv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [IDX_W-1:0]  index;
  logic signed [VAL_W-1:0] value;
  logic signed [VAL_W-1:0] r_value;
  logic              row_end;
  logic              last_row;

  modport source (output valid, mode, index, value, r_value, row_end, last_row,
                  input ready);
  modport sink   (input valid, mode, index, value, r_value, row_end, last_row,
                  output ready);
endinterface

interface srmv_out_if import srmv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  row_index;
  logic signed [ACC_W-1:0] row_product;
  logic signed [ACC_W-1:0] p_a_p;
  logic [RR_W-1:0]   r_r;
  logic              totals_final;

  modport source (output valid, row_index, row_product, p_a_p, r_r, totals_final,
                  input ready);
  modport sink   (input valid, row_index, row_product, p_a_p, r_r, totals_final,
                  output ready);
endinterface

FILE: rtl/core/srmv_ram.sv
// Generic simple dual-port RAM with registered read
module srmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/sparse_row_matvec_with_dots_top.sv
// Top level: sparse row matvec with pAp and rr accumulation on one shared multiplier
// Load item: written on transfer; nonzero without row end: vector read, then multiply;
//   the sum is added while the next item is taken.
// Row-end item: MUL, SQR, PLO, PHI, CMB, PAP on the shared 33x33 multiplier, PAP waiting
//   while the previous result is unaccepted; the result is valid in the cycle after PAP.
// Reset clears sequencer, accumulators, row counter and output valid, not the vector memory.
`include "sparse_row_matvec_with_dots_top_macros.svh"

module sparse_row_matvec_with_dots_top import srmv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  srmv_in_if.sink     in_i,
  srmv_out_if.source  out_o
);

  localparam logic signed [ACC_W-1:0] SMAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SMIN = {1'b1, {(ACC_W-1){1'b0}}};

  srmv_state_e state_q, state_d;

  // latched item
  logic signed [VAL_W-1:0] value_q, rv_q;
  logic                    row_end_q, last_q, col_ok_q;

  // accumulators
  logic signed [ACC_W-1:0] row_sum_q, pap_q;
  logic [RR_W-1:0]         rr_q;
  logic [IDX_W-1:0]        row_cnt_q;
  logic                    acc_pend_q;

  // shared multiplier and partial products
  logic signed [32:0]      mul_a, mul_b;
  logic signed [65:0]      prod_d, prod_q;
  logic signed [64:0]      lo_q;
  logic signed [VAL_W-1:0] prow_q;
  logic signed [ACC_W-1:0] term_q;

  // vector memory
  logic                    ram_we;
  logic [VEC_AW-1:0]       ram_raddr;
  logic [VAL_W-1:0]        ram_rdata;

  // output register
  logic                    out_valid_q;
  logic [IDX_W-1:0]        out_row_q;
  logic signed [ACC_W-1:0] out_prod_q, out_pap_q;
  logic [RR_W-1:0]         out_rr_q;
  logic                    out_final_q;

  logic                    in_xfer, out_free, out_load;
  logic signed [ACC_W-1:0] pap_d;
  logic signed [95:0]      full_prod;
  logic [79:0]             shifted;
  logic signed [ACC_W-1:0] term_d;
  logic [RR_W:0]           rr_sum;
  logic                    in_ok, row_ok;

  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0] a,
    input logic signed [ACC_W-1:0] b
  );
    logic signed [ACC_W:0] s;
    s = (ACC_W+1)'(a) + (ACC_W+1)'(b);
    if (s[ACC_W] != s[ACC_W-1]) begin
      sat_add = s[ACC_W] ? SMIN : SMAX;
    end else begin
      sat_add = s[ACC_W-1:0];
    end
  endfunction

  // handshakes
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign out_load   = (state_q == ST_PAP) && out_free;

  // range checks against the store depth
  assign in_ok  = 32'(in_i.index) < 32'(VECTOR_DEPTH);
  assign row_ok = 32'(row_cnt_q) < 32'(VECTOR_DEPTH);

  // vector memory: write on load transfer, read item column then row entry
  assign ram_we    = in_xfer && (in_i.mode == MODE_LOAD) && in_ok;
  assign ram_raddr = (state_q == ST_IDLE) ? VEC_AW'(in_i.index) : VEC_AW'(row_cnt_q);

  srmv_ram #(
    .WIDTH (VAL_W),
    .DEPTH (VECTOR_DEPTH)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (VEC_AW'(in_i.index)),
    .wdata_i (in_i.value),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MUL: begin
        mul_a = 33'(value_q);
        mul_b = col_ok_q ? 33'(signed'(ram_rdata)) : '0;
      end
      ST_SQR: begin
        mul_a = 33'(rv_q);
        mul_b = 33'(rv_q);
      end
      ST_PLO: begin
        mul_a = 33'(prow_q);
        mul_b = {1'b0, row_sum_q[31:0]};
      end
      ST_PHI: begin
        mul_a = 33'(prow_q);
        mul_b = 33'(signed'(row_sum_q[63:32]));
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // p[row]*V: join halves, floor shift by 16, saturate
  assign full_prod = 96'(lo_q) + (96'(prod_q) <<< 32);
  assign shifted   = full_prod[95:16];
  always_comb begin
    if ((&shifted[79:63]) || !(|shifted[79:63])) begin
      term_d = shifted[63:0];
    end else begin
      term_d = shifted[79] ? SMIN : SMAX;
    end
  end

  assign pap_d  = sat_add(pap_q, term_q);
  assign rr_sum = (RR_W+1)'(rr_q) + (RR_W+1)'(prod_q[RR_W-1:0]);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_xfer && (in_i.mode == MODE_NZ)) state_d = ST_MUL;
      ST_MUL:  state_d = row_end_q ? ST_SQR : ST_IDLE;
      ST_SQR:  state_d = ST_PLO;
      ST_PLO:  state_d = ST_PHI;
      ST_PHI:  state_d = ST_CMB;
      ST_CMB:  state_d = ST_PAP;
      ST_PAP:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // item latch and datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      value_q   <= in_i.value;
      rv_q      <= in_i.r_value;
      row_end_q <= in_i.row_end;
      last_q    <= in_i.last_row;
      col_ok_q  <= in_ok;
    end
    if ((state_q == ST_MUL) || (state_q == ST_SQR) ||
        (state_q == ST_PLO) || (state_q == ST_PHI)) begin
      prod_q <= prod_d;
    end
    if (state_q == ST_SQR) begin
      prow_q <= row_ok ? signed'(ram_rdata) : '0;
    end
    if (state_q == ST_PHI) begin
      lo_q <= prod_q[64:0];
    end
    if (state_q == ST_CMB) begin
      term_q <= term_d;
    end
  end

  // accumulators and row counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_sum_q  <= '0;
      pap_q      <= '0;
      rr_q       <= '0;
      row_cnt_q  <= '0;
      acc_pend_q <= 1'b0;
    end else begin
      // product of a mid-row nonzero is added while the next item comes in
      if ((state_q == ST_IDLE) && acc_pend_q) begin
        row_sum_q  <= sat_add(row_sum_q, prod_q[ACC_W-1:0]);
        acc_pend_q <= 1'b0;
      end
      if ((state_q == ST_MUL) && !row_end_q) begin
        acc_pend_q <= 1'b1;
      end
      if (state_q == ST_SQR) begin
        row_sum_q <= sat_add(row_sum_q, prod_q[ACC_W-1:0]);
      end
      // r*r sits in the product register during the low-half step
      if (state_q == ST_PLO) begin
        rr_q <= rr_sum[RR_W] ? {RR_W{1'b1}} : rr_sum[RR_W-1:0];
      end
      if (out_load) begin
        row_sum_q <= '0;
        if (last_q) begin
          pap_q     <= '0;
          rr_q      <= '0;
          row_cnt_q <= '0;
        end else begin
          pap_q     <= pap_d;
          row_cnt_q <= row_cnt_q + 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_row_q   <= row_cnt_q;
      out_prod_q  <= row_sum_q;
      out_pap_q   <= pap_d;
      out_rr_q    <= rr_q;
      out_final_q <= last_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.row_index    = out_row_q;
  assign out_o.row_product  = out_prod_q;
  assign out_o.p_a_p        = out_pap_q;
  assign out_o.r_r          = out_rr_q;
  assign out_o.totals_final = out_final_q;

  // checks
  `SRMV_ASSERT_ALW(a_pend_only_idle, (state_q != ST_IDLE) |-> !acc_pend_q)
  `SRMV_ASSERT(a_mul_after_idle, (state_q == ST_MUL) |-> ($past(state_q) == ST_IDLE))
  `SRMV_ASSERT(a_result_shown, out_load |=> out_valid_q)
  `SRMV_ASSERT(a_final_clears, (out_load && last_q) |=> ((pap_q == '0) && (rr_q == '0) && (row_cnt_q == '0)))

endmodule

FILE: test/srmv_row_checker.sv
// Checker for the sparse row matvec block: watches both channels, predicts each row result
`timescale 1ns / 1ps

module srmv_row_checker import srmv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  srmv_in_if   in_mon,
  srmv_out_if  out_mon,
  output int   errors_o,
  output int   pending_o,
  output int   rows_o
);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic [IDX_W-1:0]        row_index;
    logic signed [ACC_W-1:0] row_product;
    logic signed [ACC_W-1:0] p_a_p;
    logic [RR_W-1:0]         r_r;
    logic                    totals_final;
  } row_result_t;

  // predicted block state; the p store is not touched by reset, like the block
  logic signed [VAL_W-1:0] p_vec [VECTOR_DEPTH];
  logic signed [ACC_W-1:0] row_acc;
  logic signed [ACC_W-1:0] pap_acc;
  logic [ACC_W-1:0]        rr_acc;
  logic [IDX_W-1:0]        cur_row;
  row_result_t             row_results_q [$];

  // signed 64-bit add, clamped at both ends
  function automatic logic signed [ACC_W-1:0] add_clamped(logic signed [ACC_W-1:0] a,
                                                          logic signed [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) return s[ACC_W] ? ACC_MIN : ACC_MAX;
    return s[ACC_W-1:0];
  endfunction

  // p * V at Q48.48, floored down to Q32.32 and clamped
  function automatic logic signed [ACC_W-1:0] p_times_v(logic signed [VAL_W-1:0] p,
                                                        logic signed [ACC_W-1:0] v);
    logic signed [95:0] pe;
    logic signed [95:0] ve;
    logic signed [95:0] prod;
    pe = p;
    ve = v;
    prod = (pe * ve) >>> 16;
    if (prod[95:63] != {33{prod[95]}}) return prod[95] ? ACC_MIN : ACC_MAX;
    return prod[63:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] p_read(logic [IDX_W-1:0] idx);
    if (int'(idx) >= VECTOR_DEPTH) return '0;
    return p_vec[idx];
  endfunction

  // advance the predicted state by one input transfer
  task automatic predict_row_step(logic mode, logic [IDX_W-1:0] idx,
                                  logic signed [VAL_W-1:0] val,
                                  logic signed [VAL_W-1:0] rv, logic row_end,
                                  logic last_row);
    logic signed [ACC_W-1:0] a;
    logic signed [ACC_W-1:0] b;
    logic signed [ACC_W-1:0] r64;
    logic [ACC_W-1:0]        sq;
    row_result_t             res;
    if (mode == MODE_LOAD) begin
      if (int'(idx) < VECTOR_DEPTH) p_vec[idx] = val;
      return;
    end
    a = val;
    b = p_read(idx);
    row_acc = add_clamped(row_acc, a * b);
    if (!row_end) return;

    pap_acc = add_clamped(pap_acc, p_times_v(p_read(cur_row), row_acc));
    r64 = rv;
    sq = r64 * r64;
    if (rr_acc > ACC_MAX - sq) rr_acc = ACC_MAX;
    else rr_acc = rr_acc + sq;

    res.row_index    = cur_row;
    res.row_product  = row_acc;
    res.p_a_p        = pap_acc;
    res.r_r          = rr_acc[RR_W-1:0];
    res.totals_final = last_row;
    row_results_q.push_back(res);

    row_acc = '0;
    if (last_row) begin
      pap_acc = '0;
      rr_acc  = '0;
      cur_row = '0;
    end else begin
      cur_row = cur_row + 1'b1;
    end
  endtask

  task automatic field_check(string name, logic [ACC_W-1:0] exp_v, logic [ACC_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      errors_o++;
    end
  endtask

  // result side first: a result can never belong to the input taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    row_result_t exp_r;
    if (!rst_ni) begin
      row_acc   = '0;
      pap_acc   = '0;
      rr_acc    = '0;
      cur_row   = '0;
      errors_o  = 0;
      pending_o = 0;
      rows_o    = 0;
      row_results_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        rows_o++;
        if (row_results_q.size() == 0) begin
          $display("%0t ns: unexpected result transfer, expected none actual row %0d", $time,
                   out_mon.row_index);
          errors_o++;
        end else begin
          exp_r = row_results_q.pop_front();
          field_check("row_index", ACC_W'(exp_r.row_index), ACC_W'(out_mon.row_index));
          field_check("row_product", exp_r.row_product, out_mon.row_product);
          field_check("p_a_p", exp_r.p_a_p, out_mon.p_a_p);
          field_check("r_r", ACC_W'(exp_r.r_r), ACC_W'(out_mon.r_r));
          field_check("totals_final", ACC_W'(exp_r.totals_final),
                      ACC_W'(out_mon.totals_final));
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict_row_step(in_mon.mode, in_mon.index, in_mon.value, in_mon.r_value,
                         in_mon.row_end, in_mon.last_row);
      pending_o = row_results_q.size();
    end
  end

endmodule

FILE: test/testbench.sv
// Testbench top: stimulus, receiver stalls and verdict for the sparse row matvec block
`timescale 1ns / 1ps

module testbench;
  import srmv_pkg::*;

  localparam int RANDOM_ITEMS = 850;

  logic clk_i  = 1'b0;
  logic rst_ni;
  logic rx_ready = 1'b0;

  int n_errors;
  int n_pending;
  int n_rows;

  // stimulus bookkeeping: which p entries hold data, and the row the block is on
  bit   p_loaded [VECTOR_DEPTH];
  int   loaded_list [$];
  int   row_ptr;
  int   n_items;
  int   n_loads;
  int   n_nz;
  int   burst_left;
  int   rx_cnt = 0;
  int   rx_mode = 0;

  srmv_in_if  in_if ();
  srmv_out_if out_if ();

  sparse_row_matvec_with_dots_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  srmv_row_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_if),
    .out_mon   (out_if),
    .errors_o  (n_errors),
    .pending_o (n_pending),
    .rows_o    (n_rows)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  assign out_if.ready = rx_ready;

  // receiver: switches between random stall regimes
  always @(posedge clk_i) begin
    rx_cnt <= rx_cnt + 1;
    if (rx_cnt % 97 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: rx_ready <= 1'b1;
      1: rx_ready <= 1'($urandom_range(0, 1));
      2: rx_ready <= ($urandom_range(0, 3) == 0);
      default: rx_ready <= rx_cnt[3];
    endcase
  end

  // Q16.16 values: extremes, small magnitudes, or anything
  function automatic logic [VAL_W-1:0] pick_q16();
    logic [VAL_W-1:0] v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0000;
          3: v = 32'hFFFF_FFFF;
          default: v = 32'h0001_0000;
        endcase
      end
      1, 2, 3: v = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // one input transfer, with burst gaps ahead of it
  task automatic send_item(logic mode, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val,
                           logic [VAL_W-1:0] rv, logic row_end, logic last_row);
    int  gap;
    bit  took;
    if (burst_left == 0) begin
      case ($urandom_range(0, 7))
        0, 1: gap = 0;
        2:    gap = $urandom_range(10, 24);
        default: gap = $urandom_range(1, 6);
      endcase
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_if.valid    <= 1'b1;
    in_if.mode     <= mode;
    in_if.index    <= idx;
    in_if.value    <= val;
    in_if.r_value  <= rv;
    in_if.row_end  <= row_end;
    in_if.last_row <= last_row;
    // ready is stable by the falling edge, since inputs only move at rising edges
    do begin
      @(negedge clk_i);
      took = in_if.ready;
      @(posedge clk_i);
    end while (!took);
    n_items++;
    if (mode == MODE_LOAD) begin
      n_loads++;
      if (!p_loaded[idx]) begin
        p_loaded[idx] = 1'b1;
        loaded_list.push_back(idx);
      end
    end else begin
      n_nz++;
      if (row_end) row_ptr = last_row ? 0 : (row_ptr + 1) % VECTOR_DEPTH;
    end
  endtask

  // load with random content in the ignored fields
  task automatic load_entry(int idx);
    send_item(MODE_LOAD, IDX_W'(idx), pick_q16(), $urandom(), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
  endtask

  // one row of n nonzeros (n = 0 is the empty row), loads slipped in now and then
  task automatic send_row(int n, bit last);
    int cols;
    int k;
    if (!p_loaded[row_ptr]) load_entry(row_ptr);
    cols = (n == 0) ? 1 : n;
    for (k = 0; k < cols; k++) begin
      if ($urandom_range(0, 9) == 0) load_entry($urandom_range(0, VECTOR_DEPTH - 1));
      if (!p_loaded[row_ptr]) load_entry(row_ptr);
      send_item(MODE_NZ, IDX_W'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]),
                (n == 0) ? '0 : pick_q16(), pick_q16(), k == cols - 1,
                (k == cols - 1) ? last : 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int i;
    rst_ni         <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.mode     <= MODE_LOAD;
    in_if.index    <= '0;
    in_if.value    <= '0;
    in_if.r_value  <= '0;
    in_if.row_end  <= 1'b0;
    in_if.last_row <= 1'b0;
    row_ptr    = 0;
    burst_left = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extreme p entries, flags on loads are ignored
    send_item(MODE_LOAD, 0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1);
    send_item(MODE_LOAD, 1023, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0);
    send_item(MODE_LOAD, 1, 32'h0001_0000, 32'h0, 1'b0, 1'b1);
    send_item(MODE_LOAD, 2, 32'h0, 32'h0, 1'b0, 1'b0);
    send_item(MODE_LOAD, 3, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0);
    // row 0: last flag without row end, row sum clamps high, p[0]*V clamps low
    send_item(MODE_NZ, 0, 32'h8000_0000, 32'h0, 1'b0, 1'b1);
    send_item(MODE_NZ, 0, 32'h8000_0000, 32'h0, 1'b0, 1'b0);
    send_item(MODE_NZ, 1023, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0);
    // row 1: rr clamps at its maximum
    send_item(MODE_NZ, 1023, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0);
    // row 2: empty row ends the range
    send_item(MODE_NZ, 2, 32'h0, 32'h7FFF_FFFF, 1'b1, 1'b1);
    // fresh range; row 1 floors a negative p*V toward minus infinity
    send_item(MODE_NZ, 3, 32'h0000_0003, 32'h0000_0001, 1'b1, 1'b0);
    send_item(MODE_LOAD, 1, 32'h0000_0003, 32'h0, 1'b1, 1'b0);
    send_item(MODE_NZ, 3, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_item(MODE_NZ, 1023, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1);

    // random: mostly whole rows with random content, some stray loads
    while (n_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 15) begin
        load_entry($urandom_range(0, VECTOR_DEPTH - 1));
      end else begin
        case ($urandom_range(0, 9))
          0:       i = 0;
          1:       i = $urandom_range(5, 12);
          default: i = $urandom_range(1, 4);
        endcase
        send_row(i, $urandom_range(0, 5) == 0);
      end
    end
    in_if.valid <= 1'b0;

    // drain, then let the block settle
    do @(negedge clk_i); while (n_pending != 0);
    repeat (16) @(posedge clk_i);

    $display("Sent %0d input transfers (%0d loads, %0d nonzeros); checked %0d row results,",
             n_items, n_loads, n_nz, n_rows);
    $display("including clamped sums, floored p*V, empty rows and ranges of random length.");
    if (n_errors == 0 && n_pending == 0) begin
      $display("sparse_row_matvec_with_dots_top test passed");
    end else begin
      $display("sparse_row_matvec_with_dots_top test failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("sparse_row_matvec_with_dots_top test failed");
    $finish;
  end

endmodule

FILE: sparse_row_matvec_with_dots_top.f
+incdir+rtl/core
rtl/core/srmv_pkg.sv
rtl/core/srmv_if.sv
rtl/core/srmv_ram.sv
rtl/core/sparse_row_matvec_with_dots_top.sv
test/srmv_row_checker.sv
test/testbench.sv
